// ===== src/motor_feedback_unwrap_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the motor feedback unwrap decoder
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_UNWRAP_DECODER_ASSERT_SVH
`define MOTOR_FEEDBACK_UNWRAP_DECODER_ASSERT_SVH

// Same-cycle implication
`define MFUD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfud: check failed");

// Next-cycle implication
`define MFUD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfud: check failed");

`endif

// ===== src/mfud_pkg.sv =====
// ---------------------------------------------------------------------------
// mfud_pkg
// Types and constants of the motor feedback unwrap decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package mfud_pkg;

  // field widths
  localparam int unsigned ID_W    = 11;
  localparam int unsigned ENC_W   = 16;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned CUR_W   = 16;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned ANGLE_W = 48;
  localparam int unsigned OMEGA_W = 32;
  localparam int unsigned CURQ_W  = 19;
  localparam int unsigned TURN_W  = 16;

  localparam int unsigned CPT_W   = 16;
  localparam int unsigned AGAIN_W = 32;
  localparam int unsigned WGAIN_W = 24;

  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // shared multiplier: 33x33 signed covers 32-bit unsigned operands
  localparam int unsigned MUL_W   = 33;
  localparam int unsigned PROD_W  = 2 * MUL_W;

  // unwrap jump threshold
  localparam logic signed [ENC_W:0] WRAP_THRESHOLD = 17'sd4096;

  localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

  // register reset values
  localparam logic [ID_W-1:0]    RX_ID_RST   = 11'd513;
  localparam logic [CPT_W-1:0]   CPT_RST     = 16'd8192;
  localparam logic [AGAIN_W-1:0] AGAIN_RST   = 32'd3294199;
  localparam logic [WGAIN_W-1:0] WGAIN_RST   = 24'd6863;

  // register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_RX_ID     = 2'd0,
    REG_CPT       = 2'd1,
    REG_ANGLE_GN  = 2'd2,
    REG_OMEGA_GN  = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UNWRAP   = 8'b0000_0010,
    S_MUL_TURN = 8'b0000_0100,
    S_ABS      = 8'b0000_1000,
    S_MUL_ANG  = 8'b0001_0000,
    S_ROUND    = 8'b0010_0000,
    S_MUL_SPD  = 8'b0100_0000,
    S_WB       = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== src/motor_feedback_unwrap_decoder.sv =====
// ---------------------------------------------------------------------------
// motor_feedback_unwrap_decoder
// Multi-turn encoder unwrap and fixed-point scaling of one motor's feedback.
// ---------------------------------------------------------------------------
// Sequence: a matching frame steps through S_UNWRAP, S_MUL_TURN, S_ABS,
//   S_MUL_ANG, S_ROUND, S_MUL_SPD and S_WB (one 33x33 multiplier shared by
//   three products, one sequencer step per cycle, S_WB held while the output
//   stalls); a frame with a foreign id goes from S_UNWRAP to S_WB, skipping
//   the math. in_stall is high while an item is in work, and the result
//   register lets the next item enter while it waits.
// Reset (rst_n low, synchronous): registers back to defaults, turn counter
//   and last count cleared, output invalid.
`default_nettype none

module motor_feedback_unwrap_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  // APB-style configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mfud_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [mfud_pkg::DATA_W-1:0]        pwdata,
  output logic      [mfud_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready,

  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mfud_pkg::ID_W-1:0]          in_frame_id,
  input  wire logic [mfud_pkg::ENC_W-1:0]         in_encoder_count,
  input  wire logic signed [mfud_pkg::RPM_W-1:0]  in_speed_rpm,
  input  wire logic signed [mfud_pkg::CUR_W-1:0]  in_current_code,
  input  wire logic [mfud_pkg::TEMP_W-1:0]        in_temperature_raw,

  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_accepted,
  output logic signed [mfud_pkg::ANGLE_W-1:0]     out_angle_q16,
  output logic signed [mfud_pkg::OMEGA_W-1:0]     out_omega_q16,
  output logic signed [mfud_pkg::CURQ_W-1:0]      out_current_q12,
  output logic        [mfud_pkg::TEMP_W-1:0]      out_temperature,
  output logic signed [mfud_pkg::TURN_W-1:0]      out_turns
);

  import mfud_pkg::*;

  `include "motor_feedback_unwrap_decoder_assert.svh"

  // -------------------------------------------------------------------------
  // configuration registers
  // -------------------------------------------------------------------------
  logic [ID_W-1:0]    rx_id_r;
  logic [CPT_W-1:0]   cpt_r;
  logic [AGAIN_W-1:0] angle_gain_r;
  logic [WGAIN_W-1:0] omega_gain_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_id_r      <= RX_ID_RST;
      cpt_r        <= CPT_RST;
      angle_gain_r <= AGAIN_RST;
      omega_gain_r <= WGAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RX_ID:    rx_id_r      <= pwdata[ID_W-1:0];
        REG_CPT:      cpt_r        <= pwdata[CPT_W-1:0];
        REG_ANGLE_GN: angle_gain_r <= pwdata[AGAIN_W-1:0];
        REG_OMEGA_GN: omega_gain_r <= pwdata[WGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RX_ID:    prdata = {{(DATA_W-ID_W){1'b0}}, rx_id_r};
      REG_CPT:      prdata = {{(DATA_W-CPT_W){1'b0}}, cpt_r};
      REG_ANGLE_GN: prdata = angle_gain_r;
      REG_OMEGA_GN: prdata = {{(DATA_W-WGAIN_W){1'b0}}, omega_gain_r};
      default:      prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // sequencer state, unwrap state and item registers
  // -------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [ENC_W-1:0]         last_count_r, last_count_nxt;
  logic signed [TURN_W-1:0] turn_r, turn_nxt;
  logic                     match_r, match_nxt;

  // latched item payload
  logic [ENC_W-1:0]         enc_r;
  logic signed [RPM_W-1:0]  rpm_r;
  logic signed [CUR_W-1:0]  cur_r;
  logic [TEMP_W-1:0]        temp_r;

  // datapath
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r, neg_nxt;
  logic [AGAIN_W-1:0]       mag_r, mag_nxt;
  logic [ANGLE_W-1:0]       angle_r, angle_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_acc_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic signed [OMEGA_W-1:0] out_omega_r;
  logic signed [CURQ_W-1:0]  out_cur_r;
  logic [TEMP_W-1:0]         out_temp_r;
  logic signed [TURN_W-1:0]  out_turns_r;

  logic in_acc;
  logic out_load;
  logic out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_WB) && out_free;

  // -------------------------------------------------------------------------
  // shared multiplier: turn*counts, |total|*angle_gain, rpm*omega_gain
  // -------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    case (state_r)
      S_MUL_TURN: begin
        mul_a = MUL_W'(turn_r);
        mul_b = $signed({{(MUL_W-CPT_W){1'b0}}, cpt_r});
      end
      S_MUL_ANG: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = $signed({1'b0, angle_gain_r});
      end
      S_MUL_SPD: begin
        mul_a = MUL_W'(rpm_r);
        mul_b = $signed({{(MUL_W-WGAIN_W){1'b0}}, omega_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // -------------------------------------------------------------------------
  // step logic
  // -------------------------------------------------------------------------
  logic signed [ENC_W:0]    diff;     // enc - last, 17 bits signed
  logic signed [MUL_W:0]    total;    // turns*cpt + enc, 34 bits signed
  logic [63:0]              rnd;
  logic [ANGLE_W-1:0]       r48;

  localparam logic [ANGLE_W-1:0] POS_LIM = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic [ANGLE_W-1:0] NEG_LIM = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] OMEGA_HI = PROD_W'(64'sh7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] OMEGA_LO = -PROD_W'(64'sh8000_0000);

  assign diff  = $signed({1'b0, enc_r}) - $signed({1'b0, last_count_r});
  // turn product is signed: sign-extend it before adding the count
  assign total = (MUL_W+1)'($signed(prod_r[MUL_W-1:0]))
               + $signed({{(MUL_W+1-ENC_W){1'b0}}, enc_r});
  assign rnd   = prod_r[63:0] + 64'h8000;
  assign r48   = rnd[63:16];

  always_comb begin
    state_nxt      = state_r;
    last_count_nxt = last_count_r;
    turn_nxt       = turn_r;
    match_nxt      = match_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    angle_nxt      = angle_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          match_nxt = (in_frame_id == rx_id_r);
          state_nxt = S_UNWRAP;
        end
      end
      S_UNWRAP: begin
        if (!match_r) begin
          state_nxt = S_WB;            // rejected frame: state untouched
        end else begin
          // unwrap is held off while the stored count is still zero
          if (last_count_r != '0) begin
            if (diff > WRAP_THRESHOLD) begin
              if (turn_r != TURN_MIN) turn_nxt = turn_r - 16'sd1;
            end else if (diff < -WRAP_THRESHOLD) begin
              if (turn_r != TURN_MAX) turn_nxt = turn_r + 16'sd1;
            end
          end
          last_count_nxt = enc_r;
          state_nxt      = S_MUL_TURN;
        end
      end
      S_MUL_TURN: state_nxt = S_ABS;
      S_ABS: begin
        neg_nxt   = total[MUL_W];
        mag_nxt   = total[MUL_W] ? AGAIN_W'(-total) : AGAIN_W'(total);
        state_nxt = S_MUL_ANG;
      end
      S_MUL_ANG: state_nxt = S_ROUND;
      S_ROUND: begin
        // round half away from zero on the magnitude, then saturate to 48 bits
        if (neg_r) begin
          angle_nxt = (r48 > NEG_LIM) ? NEG_LIM : (ANGLE_W'(0) - r48);
        end else begin
          angle_nxt = (r48 > POS_LIM) ? POS_LIM : r48;
        end
        state_nxt = S_MUL_SPD;
      end
      S_MUL_SPD: state_nxt = S_WB;
      S_WB: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_count_r <= '0;
      turn_r       <= '0;
      match_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_count_r <= last_count_nxt;
      turn_r       <= turn_nxt;
      match_r      <= match_nxt;
    end
  end

  // payload and datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      enc_r  <= in_encoder_count;
      rpm_r  <= in_speed_rpm;
      cur_r  <= in_current_code;
      temp_r <= in_temperature_raw;
    end
    if (state_r == S_MUL_TURN || state_r == S_MUL_ANG || state_r == S_MUL_SPD) begin
      prod_r <= mul_p;
    end
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    angle_r <= angle_nxt;
  end

  // -------------------------------------------------------------------------
  // result register
  // -------------------------------------------------------------------------
  logic signed [OMEGA_W-1:0] omega_sat;
  logic signed [CURQ_W-1:0]  cur_ext;
  logic signed [CURQ_W-1:0]  cur_x5;

  always_comb begin
    if (prod_r > OMEGA_HI)      omega_sat = OMEGA_W'(OMEGA_HI);
    else if (prod_r < OMEGA_LO) omega_sat = OMEGA_W'(OMEGA_LO);
    else                        omega_sat = prod_r[OMEGA_W-1:0];
  end

  assign cur_ext = CURQ_W'(cur_r);
  assign cur_x5  = (cur_ext <<< 2) + cur_ext;   // exact, fits 19 bits

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)                     out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r   <= match_r;
      out_angle_r <= match_r ? angle_r   : '0;
      out_omega_r <= match_r ? omega_sat : '0;
      out_cur_r   <= match_r ? cur_x5    : '0;
      out_temp_r  <= match_r ? temp_r    : '0;
      out_turns_r <= match_r ? turn_r    : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_angle_q16   = out_angle_r;
  assign out_omega_q16   = out_omega_r;
  assign out_current_q12 = out_cur_r;
  assign out_temperature = out_temp_r;
  assign out_turns       = out_turns_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // turn counter moves by at most one count per item
  `MFUD_ASSERT_IMPL(a_turn_step, $past(rst_n), ((turn_r - $past(turn_r)) == 16'sd0) || ((turn_r - $past(turn_r)) == 16'sd1) || ((turn_r - $past(turn_r)) == -16'sd1))
  // a rejected frame leaves the stored count alone
  `MFUD_ASSERT_NEXT(a_reject_keeps, (state_r == S_UNWRAP) && !match_r, $stable(last_count_r) && $stable(turn_r))
  // rejected results carry all-zero fields
  `MFUD_ASSERT_IMPL(a_reject_zero, out_valid && !out_accepted, (out_angle_q16 == '0) && (out_turns == '0) && (out_omega_q16 == '0))

endmodule

`default_nettype wire
